/* rtl/tlbpt_pkg.sv */
// Shared constants and result source codes for the TLB page table translator.
`timescale 1ns / 1ps

package tlbpt_pkg;

	// Default geometry
	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int FRAME_COUNT_DEF = 256;
	localparam int OFFSET_BITS_DEF = 8;

	// Fixed field widths
	localparam int ADDR_W = 16;
	localparam int CNT_W  = 32;

	// Where a translation came from
	typedef enum logic [1:0] {
		SRC_TLB     = 2'd0,
		SRC_TABLE   = 2'd1,
		SRC_LOAD    = 2'd2,
		SRC_NOFRAME = 2'd3
	} source_t;

endpackage

/* rtl/tlbpt_cell.sv */
// One TLB entry cell: holds a tag and frame, and forwards the search beat to its neighbor.
`timescale 1ns / 1ps

module tlbpt_cell #(
	parameter int  INDEX   = 0,
	parameter int  SLOT_W  = 4,
	parameter int  PAGE_W  = 8,
	parameter int  FRAME_W = 8,
	parameter type beat_t  = logic,
	parameter type fill_t  = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  fill_t fill,
	input  beat_t beat_in,
	output beat_t beat_out
);

	logic               valid_q;
	logic [PAGE_W-1:0]  tag_q;
	logic [FRAME_W-1:0] frame_q;
	beat_t              beat_q;
	beat_t              beat_n;
	logic               match;
	logic               fill_here;

	assign fill_here = fill.en && (fill.slot == SLOT_W'(INDEX));
	assign match     = valid_q && (tag_q == beat_in.page);

	// Take the frame on the first match; keep an earlier cell's hit
	always_comb begin
		beat_n = beat_in;
		if (!beat_in.hit && match) begin
			beat_n.hit   = 1'b1;
			beat_n.frame = frame_q;
		end
	end

	// Advance the beat, set valid on fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else begin
			beat_q <= beat_n;
			if (fill_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (fill_here) begin
			tag_q   <= fill.page;
			frame_q <= fill.frame;
		end
	end

	assign beat_out = beat_q;

endmodule

/* rtl/tlbpt_page_table.sv */
// Page table memory with one read and one write port and a clearing pass after reset.
`timescale 1ns / 1ps

module tlbpt_page_table #(
	parameter int PAGE_COUNT = 256,
	parameter int PAGE_W     = 8,
	parameter int FRAME_W    = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [PAGE_W-1:0]  rd_addr,
	output logic               rd_valid,
	output logic [FRAME_W-1:0] rd_frame,
	input  logic               wr_en,
	input  logic [PAGE_W-1:0]  wr_addr,
	input  logic [FRAME_W-1:0] wr_frame,
	output logic               busy
);

	logic [FRAME_W:0]   table_mem [PAGE_COUNT];
	logic [FRAME_W:0]   rd_q;
	logic               busy_q;
	logic [PAGE_W-1:0]  clr_q;
	logic               we;
	logic [PAGE_W-1:0]  wa;
	logic [FRAME_W:0]   wd;

	// Clearing pass owns the write port until it finishes
	always_comb begin
		if (busy_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = wr_en;
			wa = wr_addr;
			wd = {1'b1, wr_frame};
		end
	end

	// Sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == PAGE_W'(PAGE_COUNT - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[wa] <= wd;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= table_mem[rd_addr];
		end
	end

	assign rd_valid = rd_q[FRAME_W];
	assign rd_frame = rd_q[FRAME_W-1:0];
	assign busy     = busy_q;

endmodule

/* rtl/tlb_page_table_translator.sv */
// Top level: TLB cell chain, page table, and the translation sequencer.
// Each address passes the two-step page-number reduction, then its search beat walks the TLB
// cell chain one cell per cycle; a new address is taken only once the previous one is resolved,
// and resolving waits while an earlier result is still held and rsp_ready is low.
// Reset: asynchronous, active low; TLB and counters clear at once, then a clearing pass
// sweeps every page table entry while req_ready stays low.
`timescale 1ns / 1ps

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF,
	parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [15:0] virtual_address,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] physical_address,
	output logic [1:0]  source,
	output logic [31:0] translation_count,
	output logic [31:0] fault_count,
	output logic [31:0] tlb_hit_count
);

	localparam int ADDR_W  = tlbpt_pkg::ADDR_W;
	localparam int CNT_W   = tlbpt_pkg::CNT_W;
	localparam int SLOT_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int PAGE_W  = $clog2(PAGE_COUNT);
	localparam int FRAME_W = $clog2(FRAME_COUNT);
	localparam int NF_W    = $clog2(FRAME_COUNT + 1);
	localparam int PN_W    = (OFFSET_BITS < ADDR_W) ? ADDR_W - OFFSET_BITS : 1;
	localparam int RCP_S   = PN_W + PAGE_W;
	localparam int PROD_W  = RCP_S + PN_W;
	localparam logic [PROD_W-1:0] RCP_M =
		PROD_W'(((64'd1 << RCP_S) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT));
	localparam logic [PN_W-1:0]   PAGE_K   = PN_W'(PAGE_COUNT);
	localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((32'd1 << OFFSET_BITS) - 1);

	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} beat_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  slot;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} fill_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FOLD,
		ST_LAUNCH,
		ST_SEARCH,
		ST_RESOLVE
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     va_q;
	logic [ADDR_W-1:0]     rem_q;
	logic [PN_W-1:0]       quo_q;
	logic                  hit_q;
	logic [FRAME_W-1:0]    tfr_q;
	logic [NF_W-1:0]       next_free_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  rsp_valid_q;
	logic [ADDR_W-1:0]     phys_q;
	tlbpt_pkg::source_t    src_q;
	logic [CNT_W-1:0]      trans_q;
	logic [CNT_W-1:0]      faults_q;
	logic [CNT_W-1:0]      hits_q;

	beat_t                 links [TLB_ENTRIES+1];
	fill_t                 fill;
	logic [PAGE_W-1:0]     page;
	logic [PROD_W-1:0]     rcp_prod;
	logic [PN_W-1:0]       fold_sub;
	logic                  pt_valid;
	logic [FRAME_W-1:0]    pt_frame;
	logic                  pt_busy;
	logic                  pt_wr_en;
	logic                  out_free;
	logic                  do_resolve;
	logic                  frame_free;
	logic                  fault;
	logic [FRAME_W-1:0]    res_frame;
	logic [31:0]           phys_full;
	tlbpt_pkg::source_t    res_src;
	logic [SLOT_W-1:0]     slot_next;
	logic                  accept;

	assign page      = rem_q[PAGE_W-1:0];
	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE) && !pt_busy;

	// Reduce the page number modulo the page count: reciprocal estimate, then fold back
	assign rcp_prod = PROD_W'(rem_q[PN_W-1:0]) * RCP_M;
	assign fold_sub = quo_q * PAGE_K;

	// Inject the search beat at the head of the chain
	always_comb begin
		links[0]       = '0;
		links[0].valid = (state_q == ST_LAUNCH);
		links[0].page  = page;
	end

	// Row of TLB cells
	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		tlbpt_cell #(
			.INDEX   (i),
			.SLOT_W  (SLOT_W),
			.PAGE_W  (PAGE_W),
			.FRAME_W (FRAME_W),
			.beat_t  (beat_t),
			.fill_t  (fill_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.fill     (fill),
			.beat_in  (links[i]),
			.beat_out (links[i+1])
		);
	end

	tlbpt_page_table #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_W     (PAGE_W),
		.FRAME_W    (FRAME_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (state_q == ST_LAUNCH),
		.rd_addr  (page),
		.rd_valid (pt_valid),
		.rd_frame (pt_frame),
		.wr_en    (pt_wr_en),
		.wr_addr  (page),
		.wr_frame (next_free_q[FRAME_W-1:0]),
		.busy     (pt_busy)
	);

	// Resolve the translation from TLB result and page table entry
	always_comb begin
		out_free   = !rsp_valid_q || rsp_ready;
		do_resolve = (state_q == ST_RESOLVE) && out_free;
		frame_free = (next_free_q != NF_W'(FRAME_COUNT));
		fault      = !hit_q && !pt_valid;
		if (hit_q) begin
			res_frame = tfr_q;
			res_src   = tlbpt_pkg::SRC_TLB;
		end else if (pt_valid) begin
			res_frame = pt_frame;
			res_src   = tlbpt_pkg::SRC_TABLE;
		end else if (frame_free) begin
			res_frame = next_free_q[FRAME_W-1:0];
			res_src   = tlbpt_pkg::SRC_LOAD;
		end else begin
			res_frame = next_free_q[FRAME_W-1:0];
			res_src   = tlbpt_pkg::SRC_NOFRAME;
		end
		phys_full = (32'(res_frame) << OFFSET_BITS) | 32'(va_q & OFF_MASK);
		pt_wr_en  = do_resolve && fault && frame_free;
		fill.en    = do_resolve && !hit_q && (pt_valid || frame_free);
		fill.slot  = slot_q;
		fill.page  = page;
		fill.frame = res_frame;
		slot_next = (slot_q == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : slot_q + 1'b1;
	end

	// Sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			va_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			hit_q       <= 1'b0;
			tfr_q       <= '0;
			next_free_q <= '0;
			slot_q      <= '0;
			rsp_valid_q <= 1'b0;
			phys_q      <= '0;
			src_q       <= tlbpt_pkg::SRC_TLB;
			trans_q     <= '0;
			faults_q    <= '0;
			hits_q      <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						va_q    <= virtual_address;
						rem_q   <= virtual_address >> OFFSET_BITS;
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					// Hold the quotient estimate from the reciprocal product
					quo_q   <= rcp_prod[RCP_S +: PN_W];
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					// Subtract the quotient's multiple to leave the wrapped page number
					rem_q   <= ADDR_W'(rem_q[PN_W-1:0] - fold_sub);
					state_q <= ST_LAUNCH;
				end
				ST_LAUNCH: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (links[TLB_ENTRIES].valid) begin
						hit_q   <= links[TLB_ENTRIES].hit;
						tfr_q   <= links[TLB_ENTRIES].frame;
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						src_q       <= res_src;
						phys_q      <= (res_src == tlbpt_pkg::SRC_NOFRAME) ? '0
							: phys_full[ADDR_W-1:0];
						if (trans_q != '1) begin
							trans_q <= trans_q + 1'b1;
						end
						if (hit_q && (hits_q != '1)) begin
							hits_q <= hits_q + 1'b1;
						end
						if (fault && (faults_q != '1)) begin
							faults_q <= faults_q + 1'b1;
						end
						if (fault && frame_free) begin
							next_free_q <= next_free_q + 1'b1;
						end
						if (fill.en) begin
							slot_q <= slot_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign physical_address  = phys_q;
	assign source            = src_q;
	assign translation_count = trans_q;
	assign fault_count       = faults_q;
	assign tlb_hit_count     = hits_q;

endmodule

/* rtl/tlbpt_checker.sv */
// Port-level checker for the TLB page table translator, bound to the top level.
`timescale 1ns / 1ps

module tlbpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [15:0] virtual_address,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] physical_address,
	input logic [1:0]  source,
	input logic [31:0] translation_count,
	input logic [31:0] fault_count,
	input logic [31:0] tlb_hit_count
);

	// Fault count moves only with a result that reports a fault
	a_fault_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fault_count) |->
			(rsp_valid && (source == tlbpt_pkg::SRC_LOAD || source == tlbpt_pkg::SRC_NOFRAME)))
		else $error("fault count moved without a fault result");

	// Hit count moves only with a result that came from the TLB
	a_hit_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tlb_hit_count) |-> (rsp_valid && source == tlbpt_pkg::SRC_TLB))
		else $error("hit count moved without a TLB result");

	// Translation count moves only as a result is shown
	a_trans_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(translation_count) |-> rsp_valid)
		else $error("translation count moved without a result");

	// No free frame means a zero address
	a_noframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && source == tlbpt_pkg::SRC_NOFRAME) |-> (physical_address == 16'd0))
		else $error("nonzero address with no frame free");

	// One address in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second address taken while one is in work");

endmodule

bind tlb_page_table_translator tlbpt_checker u_chk (.*);
